FILE: sv/vn_pkg.sv
package vn_pkg;

    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 31;
    localparam int PIPE_DEPTH  = 4 + SQRT_STAGES + DIV_STAGES;

    typedef struct packed {
        logic signed [31:0] comp_x;
        logic signed [31:0] comp_y;
        logic signed [31:0] comp_z;
    } vec_t;

    typedef struct packed {
        logic signed [31:0] unit_x;
        logic signed [31:0] unit_y;
        logic signed [31:0] unit_z;
        logic               zero_vector;
    } unit_t;

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
    } side_t;

endpackage

FILE: sv/vn_sqrt.sv
module vn_sqrt (
    input  logic          clk,
    input  logic [63:0]   sum,
    input  vn_pkg::side_t sum_side,
    output logic [31:0]   root,
    output vn_pkg::side_t root_side
);

    localparam int N = vn_pkg::SQRT_STAGES;

    logic [32:0]   r_w [0:N];
    logic [31:0]   q_w [0:N];
    logic [63:0]   s_w [0:N];
    vn_pkg::side_t d_w [0:N];

    assign r_w[0] = '0;
    assign q_w[0] = '0;
    assign s_w[0] = sum;
    assign d_w[0] = sum_side;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [34:0]   cur;
        logic [34:0]   trial;
        logic          ge;
        logic [32:0]   r_reg;
        logic [31:0]   q_reg;
        logic [63:0]   s_reg;
        vn_pkg::side_t d_reg;

        assign cur   = {r_w[k], s_w[k][2*(N-1-k)+1 -: 2]};
        assign trial = {1'b0, q_w[k], 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge clk)
        begin
            r_reg <= ge ? 33'(cur - trial) : cur[32:0];
            q_reg <= {q_w[k][30:0], ge};
            s_reg <= s_w[k];
            d_reg <= d_w[k];
        end

        assign r_w[k+1] = r_reg;
        assign q_w[k+1] = q_reg;
        assign s_w[k+1] = s_reg;
        assign d_w[k+1] = d_reg;
    end

    assign root      = q_w[N];
    assign root_side = d_w[N];

endmodule

FILE: sv/vn_lane.sv
module vn_lane (
    input  logic        clk,
    input  logic [31:0] mag,
    input  logic [31:0] len,
    input  logic        neg,
    output logic [30:0] quot,
    output logic        quot_neg
);

    localparam int N = vn_pkg::DIV_STAGES;

    logic [32:0] r_w [0:N];
    logic [30:0] q_w [0:N];
    logic [31:0] l_w [0:N];
    logic        n_w [0:N];

    assign r_w[0] = {2'b00, mag[31:1]};
    assign q_w[0] = '0;
    assign l_w[0] = len;
    assign n_w[0] = neg;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [33:0] cur;
        logic        ge;
        logic [32:0] r_reg;
        logic [30:0] q_reg;
        logic [31:0] l_reg;
        logic        n_reg;

        if (k == 0)
        begin : g_first
            assign cur = {r_w[k], mag[0]};
        end
        else
        begin : g_rest
            assign cur = {r_w[k], 1'b0};
        end

        assign ge = (cur >= {2'b00, l_w[k]});

        always_ff @(posedge clk)
        begin
            r_reg <= ge ? 33'(cur - {2'b00, l_w[k]}) : cur[32:0];
            q_reg <= {q_w[k][29:0], ge};
            l_reg <= l_w[k];
            n_reg <= n_w[k];
        end

        assign r_w[k+1] = r_reg;
        assign q_w[k+1] = q_reg;
        assign l_w[k+1] = l_reg;
        assign n_w[k+1] = n_reg;
    end

    assign quot     = q_w[N];
    assign quot_neg = n_w[N];

endmodule

FILE: sv/vector3_normalize.sv
// Fixed-point 3-vector normalizer.
// A transaction enters when start is high and busy is low; busy is always low,
// so a new vector may be issued in every clock cycle.
// The vector holds signed Q16.16 components comp_x, comp_y and comp_z.
// Each result appears on unit for exactly one cycle with done high,
// in issue order.
// The result holds signed Q1.30 components and a zero_vector flag; a zero
// input gives zero components with the flag set.
// Throughput is one vector per cycle. The latency is set by the fully
// pipelined square root, one root bit per stage over 32 stages, and the
// three divider lanes, one quotient bit per stage over 31 stages, plus
// input, multiply, sum and merge registers.
// Reset clears all in-flight transactions; no done pulse follows for them.
// The receiver cannot stall: each result must be taken in its done cycle.
module vector3_normalize (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  vn_pkg::vec_t  vector,
    output logic          done,
    output vn_pkg::unit_t unit
);

    localparam int DEPTH = vn_pkg::PIPE_DEPTH;
    localparam int DIVN  = vn_pkg::DIV_STAGES;

    logic [DEPTH-1:0] valid_reg;
    logic             accept;

    vn_pkg::vec_t     in_reg;
    logic [2:0][63:0] sq_reg;
    vn_pkg::side_t    side2_reg;
    logic [63:0]      sum_reg;
    vn_pkg::side_t    side3_reg;

    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic [31:0]      root;
    vn_pkg::side_t    root_side;
    logic [DIVN-1:0]  zero_reg;
    logic [2:0][30:0] quot;
    logic [2:0]       quot_neg;
    logic [2:0][31:0] lane_val;
    vn_pkg::unit_t    unit_reg;
    vn_pkg::unit_t    unit_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], accept};
        end
    end

    always_comb
    begin
        mag[0] = in_reg.comp_x[31] ? 32'(-in_reg.comp_x) : in_reg.comp_x;
        mag[1] = in_reg.comp_y[31] ? 32'(-in_reg.comp_y) : in_reg.comp_y;
        mag[2] = in_reg.comp_z[31] ? 32'(-in_reg.comp_z) : in_reg.comp_z;
        neg    = {in_reg.comp_z[31], in_reg.comp_y[31], in_reg.comp_x[31]};
    end

    always_ff @(posedge clk)
    begin
        in_reg        <= vector;
        sq_reg[0]     <= 64'(mag[0]) * 64'(mag[0]);
        sq_reg[1]     <= 64'(mag[1]) * 64'(mag[1]);
        sq_reg[2]     <= 64'(mag[2]) * 64'(mag[2]);
        side2_reg.mag <= mag;
        side2_reg.neg <= neg;
        sum_reg       <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        side3_reg     <= side2_reg;
        zero_reg      <= {zero_reg[DIVN-2:0], (root == 32'd0)};
    end

    vn_sqrt u_sqrt (
        .clk       (clk),
        .sum       (sum_reg),
        .sum_side  (side3_reg),
        .root      (root),
        .root_side (root_side)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        vn_lane u_lane (
            .clk      (clk),
            .mag      (root_side.mag[i]),
            .len      (root),
            .neg      (root_side.neg[i]),
            .quot     (quot[i]),
            .quot_neg (quot_neg[i])
        );

        logic [31:0] clamped;
        assign clamped     = (quot[i] > 31'h4000_0000) ? 32'h4000_0000 : {1'b0, quot[i]};
        assign lane_val[i] = zero_reg[DIVN-1] ? 32'd0
                           : (quot_neg[i] ? 32'(-clamped) : clamped);
    end

    always_comb
    begin
        unit_next.unit_x      = lane_val[0];
        unit_next.unit_y      = lane_val[1];
        unit_next.unit_z      = lane_val[2];
        unit_next.zero_vector = zero_reg[DIVN-1];
    end

    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
    end

    assign done = valid_reg[DEPTH-1];
    assign unit = unit_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(DEPTH) done)
        else $error("result strobe missing after accepted transaction");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && unit.zero_vector |->
            unit.unit_x == 32'sd0 && unit.unit_y == 32'sd0 && unit.unit_z == 32'sd0)
        else $error("zero vector result has nonzero components");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> unit.unit_x <= 32'sh4000_0000 && unit.unit_x >= -32'sh4000_0000
              && unit.unit_y <= 32'sh4000_0000 && unit.unit_y >= -32'sh4000_0000
              && unit.unit_z <= 32'sh4000_0000 && unit.unit_z >= -32'sh4000_0000)
        else $error("normalized component out of range");

endmodule

FILE: tb/sv/tb_vector3_normalize.sv
module tb_vector3_normalize;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    vn_pkg::vec_t  vector;
    logic          done;
    vn_pkg::unit_t unit;

    vn_pkg::unit_t expected_units[$];
    int            error_count;

    vector3_normalize u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .vector (vector),
        .done   (done),
        .unit   (unit)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] value);
        logic [63:0] root;
        logic [63:0] probe;
        root = 64'd0;
        for (int b = 31; b >= 0; b--)
        begin
            probe = root | (64'd1 << b);
            if (probe * probe <= value)
            begin
                root = probe;
            end
        end
        return root;
    endfunction

    function automatic logic [31:0] unit_component(input logic [31:0] comp,
                                                   input logic [63:0] magnitude);
        logic [63:0] abs_comp;
        logic [63:0] quotient;
        abs_comp = comp[31] ? {32'd0, (~comp) + 32'd1} : {32'd0, comp};
        quotient = (abs_comp << 30) / magnitude;
        if (quotient > (64'd1 << 30))
        begin
            quotient = 64'd1 << 30;
        end
        return comp[31] ? (~quotient[31:0]) + 32'd1 : quotient[31:0];
    endfunction

    function automatic vn_pkg::unit_t normalize(input vn_pkg::vec_t v);
        vn_pkg::unit_t r;
        logic [63:0]   ax;
        logic [63:0]   ay;
        logic [63:0]   az;
        logic [63:0]   magnitude;
        ax = v.comp_x[31] ? {32'd0, (~v.comp_x) + 32'd1} : {32'd0, v.comp_x};
        ay = v.comp_y[31] ? {32'd0, (~v.comp_y) + 32'd1} : {32'd0, v.comp_y};
        az = v.comp_z[31] ? {32'd0, (~v.comp_z) + 32'd1} : {32'd0, v.comp_z};
        magnitude = floor_sqrt(ax * ax + ay * ay + az * az);
        if (magnitude == 64'd0)
        begin
            r = '0;
            r.zero_vector = 1'b1;
        end
        else
        begin
            r.unit_x = unit_component(v.comp_x, magnitude);
            r.unit_y = unit_component(v.comp_y, magnitude);
            r.unit_z = unit_component(v.comp_z, magnitude);
            r.zero_vector = 1'b0;
        end
        return r;
    endfunction

    task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input bit allow_gap);
        vn_pkg::vec_t v;
        int           gap;
        v.comp_x = x;
        v.comp_y = y;
        v.comp_z = z;
        gap = allow_gap ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            vector <= vn_pkg::vec_t'({$urandom, $urandom, $urandom});
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        vector <= v;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        expected_units.push_back(normalize(v));
    endtask

    function automatic logic [31:0] random_component();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 255) - 128;
            2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            4: return 32'd0;
            default: return 32'($signed($urandom_range(0, 65535)) - 32768) << 8;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] corners[8];
        corners = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h0001_0000, 32'hFFFF_0000, 32'h0000_0003};
        send_vector(0, 0, 0, 0);
        send_vector(32'h8000_0000, 0, 0, 0);
        send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_vector(0, 32'h0001_0000, 0, 0);
        send_vector(0, 0, 32'hFFFF_0000, 0);
        send_vector(1, 1, 1, 0);
        send_vector(1, 0, 0, 0);
        send_vector(0, 32'hFFFF_FFFF, 0, 0);
        for (int i = 0; i < 8; i++)
        begin
            send_vector(corners[i], corners[7 - i], corners[(i + 3) % 8], 1);
        end
    endtask

    task automatic test_random_streaming();
        for (int i = 0; i < 650; i++)
        begin
            send_vector(random_component(), random_component(), random_component(),
                        $urandom_range(0, 3) != 0 && (i % 100) >= 30);
        end
        start <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        vn_pkg::unit_t want;
        if (rst_n && done)
        begin
            if (expected_units.size() == 0)
            begin
                $error("unexpected result %h", unit);
                error_count++;
            end
            else
            begin
                want = expected_units.pop_front();
                if (unit.unit_x !== want.unit_x)
                begin
                    $error("unit_x expected %h actual %h", want.unit_x, unit.unit_x);
                    error_count++;
                end
                if (unit.unit_y !== want.unit_y)
                begin
                    $error("unit_y expected %h actual %h", want.unit_y, unit.unit_y);
                    error_count++;
                end
                if (unit.unit_z !== want.unit_z)
                begin
                    $error("unit_z expected %h actual %h", want.unit_z, unit.unit_z);
                    error_count++;
                end
                if (unit.zero_vector !== want.zero_vector)
                begin
                    $error("zero_vector expected %b actual %b", want.zero_vector,
                           unit.zero_vector);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        error_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        vector = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_streaming();
        while (expected_units.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (vn_pkg::PIPE_DEPTH + 10) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        #150000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
